// ===== src/simplex_fbm_height_sampler_defines.svh =====
// Assertion macros shared by the height sampler RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SIMPLEX_FBM_HEIGHT_SAMPLER_DEFINES_SVH
`define SIMPLEX_FBM_HEIGHT_SAMPLER_DEFINES_SVH

// Same-cycle implication.
`define SFBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfbm assertion failed");

// Next-cycle implication.
`define SFBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfbm assertion failed");

`endif

// ===== src/sfbm_pkg.sv =====
// Types and constants of the simplex fBm height sampler.
// No dependencies; every other source file but the defines header imports this package.
package sfbm_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int TAB_AW      = 9;
  localparam int COORD_MAX_W = 16;
  localparam int FREQ_W      = 36;
  localparam int CQ_W        = 28;
  localparam int CELL_W      = CQ_W + 1 - 16;
  localparam int OFS_W       = 24;
  localparam int QDEPTH      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int SKEW_Q16    = 23987;
  localparam int UNSKEW_Q16  = 13849;
  localparam int HALF_Q16    = 32768;
  localparam int NOISE_SCALE = 40;
  localparam int NOISE_ONE   = 16384;

  localparam logic [23:0] RST_BASE_FREQ   = 24'd209715;
  localparam logic [4:0]  RST_OCTAVES     = 5'd6;
  localparam logic [14:0] RST_LACUNARITY  = 15'd8192;
  localparam logic [15:0] RST_PERSISTENCE = 16'd42598;
  localparam logic [7:0]  RST_HEIGHT_LOW  = 8'd0;
  localparam logic [7:0]  RST_HEIGHT_HIGH = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_FREQ   = 3'd0,
    CFG_OCTAVES     = 3'd1,
    CFG_LACUNARITY  = 3'd2,
    CFG_PERSISTENCE = 3'd3,
    CFG_HEIGHT_LOW  = 3'd4,
    CFG_HEIGHT_HIGH = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [23:0] base_freq;
    logic [4:0]  octaves;
    logic [14:0] lacunarity;
    logic [15:0] persistence;
    logic [7:0]  height_low;
    logic [7:0]  height_high;
  } cfg_t;

  typedef struct packed {
    kind_e                  kind;
    logic [TAB_AW-1:0]      index;
    logic [7:0]             value;
    logic [COORD_MAX_W-1:0] tx;
    logic [COORD_MAX_W-1:0] ty;
  } entry_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } back_stat_t;

endpackage

// ===== src/sfbm_intf.sv =====
// Channel interfaces of the height sampler: input requests, results, config writes.
// Depends on sfbm_pkg for field widths.
interface sfbm_item_if import sfbm_pkg::*; #(parameter int COORD_BITS = 10) ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [TAB_AW-1:0]     table_index;
  logic [7:0]            table_value;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;

  modport source(output valid, kind, table_index, table_value, x_coord, y_coord,
                 input ready);
  modport sink(input valid, kind, table_index, table_value, x_coord, y_coord,
               output ready);
endinterface

interface sfbm_result_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;
  logic [15:0]        height;

  modport source(output valid, noise_value, height, input ready);
  modport sink(input valid, noise_value, height, output ready);
endinterface

interface sfbm_cfg_if import sfbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/sfbm_front.sv =====
// Front end: accepts input requests and turns them into load or sample queue entries.
// Depends on sfbm_pkg and sfbm_item_if.
module sfbm_front import sfbm_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  sfbm_item_if.sink item_i,
  input  logic      q_full_i,
  output logic      push_o,
  output entry_t    entry_o
);

  assign item_i.ready = !q_full_i;
  assign push_o       = item_i.valid && !q_full_i;

  always_comb begin
    entry_o.kind  = item_i.kind ? KIND_SAMPLE : KIND_LOAD;
    entry_o.index = item_i.table_index;
    entry_o.value = item_i.table_value;
    entry_o.tx    = COORD_MAX_W'(item_i.x_coord);
    entry_o.ty    = COORD_MAX_W'(item_i.y_coord);
  end

endmodule

// ===== src/sfbm_queue.sv =====
// Short FIFO that decouples the front end from the sample engine.
// Depends on sfbm_pkg.
module sfbm_queue import sfbm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  input  logic    pop_i,
  output entry_t  head_o,
  output logic    head_valid_o,
  output q_stat_t stat_o
);

  localparam int QAW = $clog2(QDEPTH);

  entry_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             full, do_push, do_pop;

  assign full         = (count_q == 2'(QDEPTH));
  assign do_push      = push_i && !full;
  assign do_pop       = pop_i && (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = (count_q != 2'd0);
  assign stat_o.count = count_q;
  assign stat_o.full  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

// ===== src/sfbm_back.sv =====
// Sample engine: permutation table memory and the octave sequencer with result register.
// Depends on sfbm_pkg and sfbm_result_if.
module sfbm_back import sfbm_pkg::*; #(
  parameter int MAX_OCTAVES = 16,
  parameter int COORD_BITS  = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  entry_t     head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  sfbm_result_if.source result_o,
  output back_stat_t stat_o
);

  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam logic signed [OFS_W-1:0] G1  = OFS_W'(UNSKEW_Q16);
  localparam logic signed [OFS_W-1:0] G1M = OFS_W'(UNSKEW_Q16 - 65536);
  localparam logic signed [OFS_W-1:0] G2M = OFS_W'(2 * UNSKEW_Q16 - 65536);

  typedef enum logic [3:0] {
    ST_IDLE, ST_COORD, ST_SKEW, ST_CELL, ST_OFFS, ST_CORNERS, ST_READ,
    ST_SQ, ST_T2, ST_T4, ST_GRAD, ST_NOISE, ST_ACC, ST_FIN
  } state_e;

  state_e                  state_q;
  logic [OW-1:0]           oct_q, n_q, n_sel;
  logic [2:0]              rstep_q;
  logic [1:0]              corner_q;
  logic                    out_valid_q;

  logic [COORD_BITS-1:0]   tx_q, ty_q;
  logic [FREQ_W-1:0]       freq_q;
  logic [15:0]             amp_q;
  logic [CQ_W-1:0]         px_q, py_q, s_q;
  logic [CELL_W-1:0]       i_q, j_q;
  logic signed [OFS_W-1:0] dx_q [3];
  logic signed [OFS_W-1:0] dy_q [3];
  logic                    i1_q;
  logic [7:0]              a_q, b_q, c_q;
  logic [2:0]              hsh_q [3];
  logic [15:0]             t_q, t2_q, t4_q;
  logic signed [23:0]      nsum_q;
  logic signed [31:0]      noise_q, total_q;
  logic signed [15:0]      noise_out_q;
  logic [15:0]             height_q;

  logic [7:0]              tab_q [TABLE_DEPTH];
  logic [7:0]              rd_q;
  logic [TAB_AW-1:0]       raddr;
  logic                    mem_we, start, fin_go;

  logic [COORD_BITS+FREQ_W-1:0] mx, my;
  logic [FREQ_W+14:0]      mf;
  logic [CQ_W:0]           psum, xs, ys;
  logic [CQ_W+16:0]        ms;
  logic [CELL_W+14:0]      tm;
  logic [31:0]             x0w, y0w;
  logic                    i1_d;
  logic signed [OFS_W-1:0] cdx, cdy;
  logic signed [2*OFS_W-1:0] sqx, sqy;
  logic signed [33:0]      tsum;
  logic [31:0]             tt, tt4, ap;
  logic [2:0]              hc;
  logic signed [OFS_W+1:0] ue, ve, ga, gb, grad;
  logic signed [OFS_W+18:0] cprod;
  logic signed [31:0]      nsx;
  logic signed [48:0]      wprod;
  logic signed [15:0]      tcl;
  logic signed [8:0]       diff;
  logic signed [16:0]      hv;
  logic signed [25:0]      hp;
  logic [TAB_AW-1:0]       ci, cj;

  assign pop_o  = (state_q == ST_IDLE) && head_valid_i;
  assign mem_we = pop_o && (head_i.kind == KIND_LOAD);
  assign start  = pop_o && (head_i.kind == KIND_SAMPLE);
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || result_o.ready);
  assign n_sel  = (32'(cfg_i.octaves) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                      : OW'(cfg_i.octaves);

  assign result_o.valid       = out_valid_q;
  assign result_o.noise_value = noise_out_q;
  assign result_o.height      = height_q;
  assign stat_o.busy          = (state_q != ST_IDLE);
  assign stat_o.out_full      = out_valid_q;

  // Octave datapath, one step per sequencer state.
  assign mx   = tx_q * freq_q;
  assign my   = ty_q * freq_q;
  assign mf   = freq_q * cfg_i.lacunarity;
  assign psum = {1'b0, px_q} + {1'b0, py_q};
  assign ms   = psum * 16'(SKEW_Q16);
  assign xs   = {1'b0, px_q} + {1'b0, s_q};
  assign ys   = {1'b0, py_q} + {1'b0, s_q};
  assign tm   = ({1'b0, i_q} + {1'b0, j_q}) * 14'(UNSKEW_Q16);
  assign x0w  = 32'(px_q) - 32'({i_q, 16'h0000}) + 32'(tm);
  assign y0w  = 32'(py_q) - 32'({j_q, 16'h0000}) + 32'(tm);
  assign i1_d = (dx_q[0] > dy_q[0]);

  assign cdx  = dx_q[corner_q];
  assign cdy  = dy_q[corner_q];
  assign sqx  = cdx * cdx;
  assign sqy  = cdy * cdy;
  assign tsum = 34'sd32768 - $signed({2'b00, sqx[47:16]}) - $signed({2'b00, sqy[47:16]});
  assign tt   = t_q * t_q;
  assign tt4  = t2_q * t2_q;
  assign hc   = hsh_q[corner_q];
  assign ue   = hc[2] ? cdy : cdx;
  assign ve   = hc[2] ? cdx : cdy;
  assign ga   = hc[0] ? -ue : ue;
  assign gb   = hc[1] ? -(ve <<< 1) : (ve <<< 1);
  assign grad = ga + gb;
  assign cprod = $signed({1'b0, t4_q}) * grad;

  assign nsx   = nsum_q;
  assign wprod = noise_q * $signed({1'b0, amp_q});
  assign ap    = amp_q * cfg_i.persistence;

  always_comb begin
    if (total_q > 32'sd16384) begin
      tcl = 16'sd16384;
    end else if (total_q < -32'sd16384) begin
      tcl = -16'sd16384;
    end else begin
      tcl = total_q[15:0];
    end
  end
  assign diff = $signed({1'b0, cfg_i.height_high}) - $signed({1'b0, cfg_i.height_low});
  assign hv   = tcl + 17'sd16384;
  assign hp   = hv * diff;

  // Table read address for each step of the hash lookup.
  assign ci = {1'b0, i_q[7:0]};
  assign cj = {1'b0, j_q[7:0]};
  always_comb begin
    unique case (rstep_q)
      3'd1:    raddr = cj + TAB_AW'(!i1_q);
      3'd2:    raddr = cj + 9'd1;
      3'd3:    raddr = ci + {1'b0, a_q};
      3'd4:    raddr = ci + TAB_AW'(i1_q) + {1'b0, b_q};
      3'd5:    raddr = ci + 9'd1 + {1'b0, c_q};
      default: raddr = cj;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tab_q[head_i.index] <= head_i.value;
    rd_q <= tab_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oct_q       <= '0;
      n_q         <= '0;
      rstep_q     <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          rstep_q <= '0;
          if (start) begin
            n_q     <= n_sel;
            oct_q   <= '0;
            state_q <= (n_sel == '0) ? ST_FIN : ST_COORD;
          end
        end
        ST_COORD:   state_q <= ST_SKEW;
        ST_SKEW:    state_q <= ST_CELL;
        ST_CELL:    state_q <= ST_OFFS;
        ST_OFFS:    state_q <= ST_CORNERS;
        ST_CORNERS: begin
          rstep_q <= 3'd1;
          state_q <= ST_READ;
        end
        ST_READ: begin
          if (rstep_q == 3'd6) begin
            rstep_q  <= '0;
            corner_q <= '0;
            state_q  <= ST_SQ;
          end else begin
            rstep_q <= rstep_q + 3'd1;
          end
        end
        ST_SQ: state_q <= ST_T2;
        ST_T2: state_q <= ST_T4;
        ST_T4: state_q <= ST_GRAD;
        ST_GRAD: begin
          if (corner_q == 2'd2) begin
            state_q <= ST_NOISE;
          end else begin
            corner_q <= corner_q + 2'd1;
            state_q  <= ST_SQ;
          end
        end
        ST_NOISE: state_q <= ST_ACC;
        ST_ACC: begin
          oct_q   <= oct_q + 1'b1;
          state_q <= (OW'(oct_q + 1'b1) == n_q) ? ST_FIN : ST_COORD;
        end
        ST_FIN: begin
          if (fin_go) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          tx_q    <= head_i.tx[COORD_BITS-1:0];
          ty_q    <= head_i.ty[COORD_BITS-1:0];
          freq_q  <= FREQ_W'(cfg_i.base_freq);
          amp_q   <= cfg_i.persistence;
          total_q <= '0;
        end
      end
      ST_COORD: begin
        px_q <= mx[8 +: CQ_W];
        py_q <= my[8 +: CQ_W];
      end
      ST_SKEW: begin
        s_q    <= ms[16 +: CQ_W];
        freq_q <= mf[12 +: FREQ_W];
      end
      ST_CELL: begin
        i_q <= xs[CQ_W:16];
        j_q <= ys[CQ_W:16];
      end
      ST_OFFS: begin
        dx_q[0] <= $signed(x0w[OFS_W-1:0]);
        dy_q[0] <= $signed(y0w[OFS_W-1:0]);
      end
      ST_CORNERS: begin
        i1_q    <= i1_d;
        dx_q[1] <= dx_q[0] + (i1_d ? G1M : G1);
        dy_q[1] <= dy_q[0] + (i1_d ? G1 : G1M);
        dx_q[2] <= dx_q[0] + G2M;
        dy_q[2] <= dy_q[0] + G2M;
        nsum_q  <= '0;
      end
      ST_READ: begin
        unique case (rstep_q)
          3'd1:    a_q <= rd_q;
          3'd2:    b_q <= rd_q;
          3'd3:    c_q <= rd_q;
          3'd4:    hsh_q[0] <= rd_q[2:0];
          3'd5:    hsh_q[1] <= rd_q[2:0];
          3'd6:    hsh_q[2] <= rd_q[2:0];
          default: a_q <= a_q;
        endcase
      end
      ST_SQ:   t_q  <= tsum[33] ? 16'd0 : tsum[15:0];
      ST_T2:   t2_q <= tt[31:16];
      ST_T4:   t4_q <= tt4[31:16];
      ST_GRAD: nsum_q <= nsum_q + $signed(cprod[16 +: 24]);
      ST_NOISE: noise_q <= (nsx * NOISE_SCALE) >>> 2;
      ST_ACC: begin
        total_q <= total_q + $signed(wprod[47:16]);
        amp_q   <= ap[31:16];
      end
      ST_FIN: begin
        if (fin_go) begin
          noise_out_q <= tcl;
          height_q    <= {cfg_i.height_low, 8'h00} + hp[22:7];
        end
      end
      default: t_q <= t_q;
    endcase
  end

endmodule

// ===== src/simplex_fbm_height_sampler.sv =====
// A sample with n octaves (octaves clamped to MAX_OCTAVES) runs the octave sequence n times;
// each pass holds the six table reads, one at a time, and the corner datapath shared by the
// three simplex corners. The engine takes one sample at a time and starts the next only once
// the last result is in the output register, which waits while results are not taken. A load
// is written when the idle engine pops it. The input accepts while the two-entry queue has
// room. Reset clears control state, loads config defaults; table is undefined until loaded.
`include "simplex_fbm_height_sampler_defines.svh"

module simplex_fbm_height_sampler import sfbm_pkg::*; #(
  parameter int MAX_OCTAVES = 16,
  parameter int COORD_BITS  = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfbm_item_if.sink     item_i,
  sfbm_result_if.source result_o,
  sfbm_cfg_if.sink      cfg_i
);

  cfg_t       cfg_q;
  entry_t     entry, head;
  logic       push, pop, head_valid;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_freq   <= RST_BASE_FREQ;
      cfg_q.octaves     <= RST_OCTAVES;
      cfg_q.lacunarity  <= RST_LACUNARITY;
      cfg_q.persistence <= RST_PERSISTENCE;
      cfg_q.height_low  <= RST_HEIGHT_LOW;
      cfg_q.height_high <= RST_HEIGHT_HIGH;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BASE_FREQ:   cfg_q.base_freq   <= cfg_i.data;
        CFG_OCTAVES:     cfg_q.octaves     <= cfg_i.data[4:0];
        CFG_LACUNARITY:  cfg_q.lacunarity  <= cfg_i.data[14:0];
        CFG_PERSISTENCE: cfg_q.persistence <= cfg_i.data[15:0];
        CFG_HEIGHT_LOW:  cfg_q.height_low  <= cfg_i.data[7:0];
        CFG_HEIGHT_HIGH: cfg_q.height_high <= cfg_i.data[7:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  sfbm_front #(.COORD_BITS(COORD_BITS)) u_front (
    .item_i   (item_i),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .entry_o  (entry)
  );

  sfbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .stat_o       (q_stat)
  );

  sfbm_back #(.MAX_OCTAVES(MAX_OCTAVES), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .result_o     (result_o),
    .stat_o       (b_stat)
  );

  `SFBM_ASSERT_NEXT(a_accept_queued, item_i.valid && item_i.ready, q_stat.count != 2'd0)
  `SFBM_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= 2'(QDEPTH))
  `SFBM_ASSERT_NOW(a_result_from_engine, $rose(result_o.valid), $past(b_stat.busy))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the simplex fBm height sampler.
// Uses sfbm_pkg and the channel interfaces in sfbm_intf.sv; predicts most results with an
// integer model of the octave sum (typed rows carry their own expected values) and compares every field.
module testbench import sfbm_pkg::*; ();

  typedef struct {
    logic signed [15:0] noise;
    logic [15:0]        height;
  } height_t;

  typedef struct {
    kind_e       kind;
    logic [8:0]  index;
    logic [7:0]  value;
    logic [9:0]  x;
    logic [9:0]  y;
    bit          flat;
    bit          typed;
    height_t     want;
  } row_t;

  typedef struct {
    logic [23:0] freq;
    logic [4:0]  octaves;
    logic [14:0] lac;
    logic [15:0] pers;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int          count;
  } setting_t;

  logic clk_i;
  logic rst_ni;

  sfbm_item_if #(.COORD_BITS(10)) item_bus ();
  sfbm_result_if                  result_bus ();
  sfbm_cfg_if                     cfg_bus ();

  simplex_fbm_height_sampler #(.MAX_OCTAVES(16), .COORD_BITS(10)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  logic [7:0]  perm [TABLE_DEPTH];
  logic [23:0] m_freq;
  logic [4:0]  m_octaves;
  logic [14:0] m_lac;
  logic [15:0] m_pers;
  logic [7:0]  m_lo;
  logic [7:0]  m_hi;

  height_t pending_heights[$];
  int      errors;
  int      quiet_cycles;
  bit      no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint corner_term(int unsigned hash, longint dx, longint dy);
    longint t, t2, t4, u, v, a, b;
    logic [2:0] h;
    t = HALF_Q16 - ((dx * dx) >>> 16) - ((dy * dy) >>> 16);
    if (t < 0) return 0;
    t2 = (t * t) >>> 16;
    t4 = (t2 * t2) >>> 16;
    h = hash[2:0];
    u = (h < 4) ? dx : dy;
    v = (h < 4) ? dy : dx;
    a = h[0] ? -u : u;
    b = h[1] ? -2 * v : 2 * v;
    return (t4 * (a + b)) >>> 16;
  endfunction

  function automatic int unsigned perm_at(longint idx);
    return perm[idx & (TABLE_DEPTH - 1)];
  endfunction

  function automatic longint octave_noise(longint px, longint py);
    longint s, i, j, t, x0, y0, x1, y1, x2, y2, ci, cj, n0, n1, n2;
    longint i1, j1;
    s = ((px + py) * SKEW_Q16) >> 16;
    i = (px + s) >> 16;
    j = (py + s) >> 16;
    t = (i + j) * UNSKEW_Q16;
    x0 = px - (i << 16) + t;
    y0 = py - (j << 16) + t;
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    x1 = x0 - i1 * 65536 + UNSKEW_Q16;
    y1 = y0 - j1 * 65536 + UNSKEW_Q16;
    x2 = x0 - 65536 + 2 * UNSKEW_Q16;
    y2 = y0 - 65536 + 2 * UNSKEW_Q16;
    ci = i & 255;
    cj = j & 255;
    n0 = corner_term(perm_at(ci + perm_at(cj)), x0, y0);
    n1 = corner_term(perm_at(ci + i1 + perm_at(cj + j1)), x1, y1);
    n2 = corner_term(perm_at(ci + 1 + perm_at(cj + 1)), x2, y2);
    return (NOISE_SCALE * (n0 + n1 + n2)) >>> 2;
  endfunction

  function automatic height_t sample_height(logic [9:0] x, logic [9:0] y);
    longint freq, amp, total, diff, h, px, py;
    int n;
    height_t r;
    n = (m_octaves > 16) ? 16 : m_octaves;
    freq = m_freq;
    amp = m_pers;
    total = 0;
    for (int k = 0; k < n; k++) begin
      px = ((longint'(x) * freq) >> 8) & ((64'd1 << CQ_W) - 1);
      py = ((longint'(y) * freq) >> 8) & ((64'd1 << CQ_W) - 1);
      total += (octave_noise(px, py) * amp) >>> 16;
      freq = ((freq * m_lac) >> 12) & ((64'd1 << FREQ_W) - 1);
      amp = (amp * m_pers) >> 16;
    end
    if (total > NOISE_ONE) total = NOISE_ONE;
    if (total < -NOISE_ONE) total = -NOISE_ONE;
    diff = longint'(m_hi) - longint'(m_lo);
    h = longint'(m_lo) * 256 + (((total + NOISE_ONE) * diff) >>> 7);
    r.noise = total[15:0];
    r.height = h[15:0];
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 11);
  endfunction

  // Drives one request; the expectation is queued at the accepting edge.
  task automatic send_item(row_t r);
    while (idle_now()) begin
      item_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid       = 1'b1;
    item_bus.kind        = r.kind;
    item_bus.table_index = r.index;
    item_bus.table_value = r.value;
    item_bus.x_coord     = r.x;
    item_bus.y_coord     = r.y;
    do @(posedge clk_i); while (!item_bus.ready);
    if (r.kind == KIND_LOAD) begin
      perm[r.index] = r.value;
    end else if (r.typed) begin
      pending_heights.push_back(r.want);
    end else begin
      pending_heights.push_back(sample_height(r.x, r.y));
    end
    @(negedge clk_i);
    item_bus.valid = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_BASE_FREQ:   m_freq = data[23:0];
      CFG_OCTAVES:     m_octaves = data[4:0];
      CFG_LACUNARITY:  m_lac = data[14:0];
      CFG_PERSISTENCE: m_pers = data[15:0];
      CFG_HEIGHT_LOW:  m_lo = data[7:0];
      default:         m_hi = data[7:0];
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic apply_setting(setting_t s);
    drain();
    write_reg(CFG_BASE_FREQ, s.freq);
    write_reg(CFG_OCTAVES, 24'(s.octaves));
    write_reg(CFG_LACUNARITY, 24'(s.lac));
    write_reg(CFG_PERSISTENCE, 24'(s.pers));
    write_reg(CFG_HEIGHT_LOW, 24'(s.lo));
    write_reg(CFG_HEIGHT_HIGH, 24'(s.hi));
  endtask

  always @(negedge clk_i) begin
    result_bus.ready <= !idle_now();
  end

  always @(posedge clk_i) begin
    height_t w;
    if (!rst_ni || (item_bus.valid && item_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
        || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("Verification failed");
        $finish;
      end
    end
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected result noise=%0d height=%0d", $time,
                 result_bus.noise_value, result_bus.height);
        errors++;
      end else begin
        w = pending_heights.pop_front();
        if (w.noise !== result_bus.noise_value) begin
          $display("%0t: noise_value expected %0d actual %0d", $time, w.noise,
                   result_bus.noise_value);
          errors++;
        end
        if (w.height !== result_bus.height) begin
          $display("%0t: height expected %0d actual %0d", $time, w.height,
                   result_bus.height);
          errors++;
        end
      end
    end
  end

  row_t     rows[$];
  setting_t settings[$];

  function automatic row_t mk(kind_e k, int idx, int val, int x, int y, bit flat,
                              bit typed, int n, int h);
    row_t r;
    r.kind = k; r.index = 9'(idx); r.value = 8'(val); r.x = 10'(x); r.y = 10'(y);
    r.flat = flat; r.typed = typed; r.want.noise = 16'(n); r.want.height = 16'(h);
    return r;
  endfunction

  function automatic setting_t st(int f, int o, int l, int p, int lo, int hi, int c);
    setting_t s;
    s.freq = 24'(f); s.octaves = 5'(o); s.lac = 15'(l); s.pers = 16'(p);
    s.lo = 8'(lo); s.hi = 8'(hi); s.count = c;
    return s;
  endfunction

  initial begin
    row_t     r;
    setting_t flat_cfg;
    bit       flat_now;
    no_idle = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.kind = KIND_LOAD;
    item_bus.table_index = '0;
    item_bus.table_value = '0;
    item_bus.x_coord = '0;
    item_bus.y_coord = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_BASE_FREQ;
    cfg_bus.data = '0;
    m_freq = RST_BASE_FREQ;
    m_octaves = RST_OCTAVES;
    m_lac = RST_LACUNARITY;
    m_pers = RST_PERSISTENCE;
    m_lo = RST_HEIGHT_LOW;
    m_hi = RST_HEIGHT_HIGH;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every entry is written before the first sample can read it.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(mk(KIND_LOAD, i, (i == 0) ? 0 : (i == 511) ? 255 : $urandom_range(255),
                   0, 0, 0, 0, 0, 0));
    end

    rows.push_back(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 1023, 1023, 0, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 0, 1023, 0, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 1023, 0, 0, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 1, 1, 0, 0, 0, 0));
    rows.push_back(mk(KIND_LOAD, 511, 255, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 512, 341, 0, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 0, 0, 1, 1, 0, 32640));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 1023, 1023, 1, 1, 0, 32640));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 1023, 0, 1, 1, 0, 32640));
    rows.push_back(mk(KIND_LOAD, 0, 0, 0, 0, 1, 0, 0, 0));
    rows.push_back(mk(KIND_SAMPLE, 0, 0, 0, 1023, 1, 1, 0, 32640));

    // With zero octaves the noise is zero and the height is the midpoint.
    flat_cfg = st(RST_BASE_FREQ, 0, RST_LACUNARITY, RST_PERSISTENCE, 0, 255, 0);
    flat_now = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].flat != flat_now) begin
        apply_setting(flat_cfg);
        flat_now = rows[i].flat;
      end
      send_item(rows[i]);
    end

    settings.push_back(st(24'hFFFFFF, 31, 32767, 65535, 255, 0, 25));
    settings.push_back(st(0, 1, 4096, 0, 0, 255, 20));
    settings.push_back(st(209715, 3, 8192, 42598, 10, 200, 60));
    settings.push_back(st(24'h080000, 2, 4096, 65535, 255, 255, 50));
    settings.push_back(st(24'h7FFFFF, 4, 32767, 32768, 200, 20, 50));
    settings.push_back(st(24'h001000, 16, 16384, 50000, 0, 255, 20));
    settings.push_back(st(24'h123456, 2, 6000, 60000, 0, 0, 50));
    settings.push_back(st(24'h0A0000, 1, 12000, 65535, 128, 64, 50));

    foreach (settings[p]) begin
      apply_setting(settings[p]);
      no_idle = (p == 3);
      for (int n = 0; n < settings[p].count; n++) begin
        if ($urandom_range(99) < 20) begin
          r = mk(KIND_LOAD, $urandom_range(511), $urandom_range(255), $urandom_range(1023),
                 $urandom_range(1023), 0, 0, 0, 0);
        end else begin
          r = mk(KIND_SAMPLE, $urandom_range(511), $urandom_range(255),
                 $urandom_range(1023), $urandom_range(1023), 0, 0, 0, 0);
        end
        send_item(r);
      end
    end
    no_idle = 1'b0;

    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== simplex_fbm_height_sampler.f =====
+incdir+src
src/sfbm_pkg.sv
src/sfbm_intf.sv
src/sfbm_front.sv
src/sfbm_queue.sv
src/sfbm_back.sv
src/simplex_fbm_height_sampler.sv
tb/testbench.sv
